@@ rtl/twodo_pkg.sv @@
// ----------------------------------------------------------------------------
// twodo_pkg: shared types and constants of the three wheel odometry block
// command codes, register indexes, cordic gain and angle table, saturation
// ----------------------------------------------------------------------------
package twodo_pkg;

    // command codes of an input item
    localparam logic [1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [1:0] CMD_SET_POS  = 2'd1;
    localparam logic [1:0] CMD_SET_HEAD = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_CIRC    = 3'd0;
    localparam logic [2:0] REG_INV_TW  = 3'd1;
    localparam logic [2:0] REG_BACK_R  = 3'd2;
    localparam logic [2:0] REG_BACK_OF = 3'd3;
    localparam logic [2:0] REG_CORR_EN = 3'd4;

    // cordic start value, 1/gain in q30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    // round(2^32 / (2*pi)), turns per radian in q32
    localparam logic signed [32:0] TURNS_PER_RAD = 33'sd683565276;

    typedef logic signed [31:0] t_pos;

    // atan(2^-i) in 32-bit turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic t_pos sat32(input logic signed [47:0] v);
        t_pos r;
        if (v > 48'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/three_wheel_odometry_update.sv @@
// ----------------------------------------------------------------------------
// three_wheel_odometry_update: dead-reckoning pose tracker, three tracking wheels
// one shared multiplier and one cordic unit under a small sequencer
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one command item: a wheel sample,
// a position load or a heading load. Output channel: o_valid / i_stall carries
// one result item per command, the pose after that command.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write
// only while the block is idle.
// A load or an unused command goes from idle straight to the finish state. A
// wheel sample takes 12 multiplies on the shared multiplier, each through the
// load, wait and done states, plus one cordic pass, plus a second cordic pass
// when the offset correction is on. o_stall is high while an item is at work.
// A finished result waits in the output register; while the receiver stalls,
// a new item is still taken and worked, and its result waits until the
// output register frees.
// Reset clears pose, configuration and the output valid.
// ----------------------------------------------------------------------------
module three_wheel_odometry_update #(
    parameter int ANGLE_BITS = 24,
    parameter int TRIG_STEPS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_command,
    input  logic signed [15:0]           i_left_travel,
    input  logic signed [15:0]           i_right_travel,
    input  logic signed [15:0]           i_back_travel,
    input  logic signed [31:0]           i_new_x,
    input  logic signed [31:0]           i_new_y,
    input  logic [ANGLE_BITS-1:0]        i_new_heading,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [23:0]                  i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [31:0]           o_x_position,
    output logic signed [31:0]           o_y_position,
    output logic [ANGLE_BITS-1:0]        o_heading
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_LOAD, ST_MUL_WAIT, ST_MUL_DONE, ST_COR_RUN, ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_LEFT, OP_RIGHT, OP_BACK, OP_TURN, OP_FRAC_LO, OP_FRAC_HI,
        OP_SIDE_A, OP_SIDE_B, OP_X_COS, OP_X_SIN, OP_Y_SIN, OP_Y_COS
    } t_op;

    t_state r_state;
    t_op    r_op;

    // configuration
    logic [23:0]        r_circ;
    logic [23:0]        r_itw;
    logic signed [23:0] r_rb;
    logic signed [23:0] r_roff;
    logic               r_corr;

    // pose
    logic [ANGLE_BITS-1:0] r_heading;
    twodo_pkg::t_pos       r_x;
    twodo_pkg::t_pos       r_y;

    // item and intermediate values
    logic signed [15:0] r_lt, r_rt, r_bt;
    logic signed [28:0] r_dl, r_dr, r_db, r_v;
    logic signed [53:0] r_hd;
    logic [63:0]        r_fa;
    logic [ANGLE_BITS-1:0] r_dang;
    logic signed [65:0] r_ta;
    twodo_pkg::t_pos    r_h;

    // shared multiplier
    logic signed [32:0] r_ma, r_mb, n_ma, n_mb;
    logic signed [65:0] r_p;
    logic signed [65:0] w_prod;

    // cordic
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    logic [5:0]         r_iter;
    logic signed [32:0] r_c, r_s;

    logic               r_out_valid;
    twodo_pkg::t_pos    r_ox, r_oy;
    logic [ANGLE_BITS-1:0] r_ohead;

    logic               w_accept;
    logic               w_out_free;
    logic signed [63:0] w_hd64;
    logic signed [29:0] w_diff;
    logic [63:0]        w_frac, w_frac_r;
    logic [ANGLE_BITS-1:0] n_dang, n_heading;
    logic signed [28:0] n_v;
    logic signed [47:0] w_h_plain, w_h_corr;
    logic signed [66:0] w_side;
    logic signed [67:0] w_dx, w_dy;
    twodo_pkg::t_pos    n_x, n_y, n_h;
    logic [31:0]        w_turn, w_turn_f;
    logic               w_flip;
    logic signed [33:0] w_sx, w_sy, w_at, n_cx, n_cy, n_cz, w_cfin_x, w_cfin_y;
    logic               w_last;

    assign w_accept   = i_valid && !o_stall;
    assign o_stall    = (r_state != ST_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_valid      = r_out_valid;
    assign o_x_position = r_ox;
    assign o_y_position = r_oy;
    assign o_heading    = r_ohead;

    assign w_prod = r_ma * r_mb;
    assign w_hd64 = 64'(r_hd);
    assign w_diff = 30'(r_dr) - 30'(r_dl);

    // heading change as a rounded binary angle
    assign w_frac   = r_fa + {r_p[31:0], 32'd0};
    assign w_frac_r = w_frac + (64'd1 << (63 - ANGLE_BITS));
    assign n_dang   = ANGLE_BITS'(w_frac_r >> (64 - ANGLE_BITS));
    assign n_v      = 29'((30'(r_dl) + 30'(r_dr)) >>> 1);
    assign n_heading = r_heading + r_dang;

    // sideways travel
    assign w_h_plain = 48'(r_db) + 48'(r_ta) + 48'(r_p >>> 16);
    assign w_side    = 67'(r_ta) + 67'(r_p);
    assign w_h_corr  = 48'(r_db) + 48'(r_roff) - 48'(w_side >>> 30);
    assign n_h = twodo_pkg::sat32(r_corr ? w_h_corr : w_h_plain);

    // rotated travel
    assign w_dx = 68'(r_ta) - 68'(r_p);
    assign w_dy = 68'(r_ta) + 68'(r_p);
    assign n_x  = twodo_pkg::sat32(48'(r_x) + 48'(w_dx >>> 30));
    assign n_y  = twodo_pkg::sat32(48'(r_y) + 48'(w_dy >>> 30));

    // cordic start: fold into the right half plane
    assign w_turn   = (r_op == OP_FRAC_HI) ? (32'(n_dang) << (32 - ANGLE_BITS))
                                           : (32'(n_heading) << (32 - ANGLE_BITS));
    assign w_flip   = (w_turn + 32'h40000000) >= 32'h80000000;
    assign w_turn_f = w_flip ? (w_turn + 32'h80000000) : w_turn;

    // cordic step
    assign w_sx = r_cx >>> r_iter[4:0];
    assign w_sy = r_cy >>> r_iter[4:0];
    assign w_at = $signed({2'b00, twodo_pkg::atan_turn(r_iter[4:0])});
    assign n_cx = r_cz[33] ? (r_cx + w_sy) : (r_cx - w_sy);
    assign n_cy = r_cz[33] ? (r_cy - w_sx) : (r_cy + w_sx);
    assign n_cz = r_cz[33] ? (r_cz + w_at) : (r_cz - w_at);
    assign w_cfin_x = r_flip ? -n_cx : n_cx;
    assign w_cfin_y = r_flip ? -n_cy : n_cy;
    assign w_last   = (r_iter == 6'(TRIG_STEPS - 1));

    // multiplier operand select
    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (r_op)
            OP_LEFT: begin
                n_ma = 33'(r_lt);
                n_mb = $signed({9'd0, r_circ});
            end
            OP_RIGHT: begin
                n_ma = 33'(r_rt);
                n_mb = $signed({9'd0, r_circ});
            end
            OP_BACK: begin
                n_ma = 33'(r_bt);
                n_mb = $signed({9'd0, r_circ});
            end
            OP_TURN: begin
                n_ma = 33'(w_diff);
                n_mb = $signed({9'd0, r_itw});
            end
            OP_FRAC_LO: begin
                n_ma = $signed({1'b0, w_hd64[31:0]});
                n_mb = twodo_pkg::TURNS_PER_RAD;
            end
            OP_FRAC_HI: begin
                n_ma = $signed({w_hd64[63], w_hd64[63:32]});
                n_mb = twodo_pkg::TURNS_PER_RAD;
            end
            OP_SIDE_A: begin
                n_ma = r_corr ? 33'(r_roff) : 33'(w_hd64 >>> 32);
                n_mb = r_corr ? r_c : 33'(r_rb);
            end
            OP_SIDE_B: begin
                n_ma = r_corr ? 33'(r_rb) : $signed({17'd0, w_hd64[31:16]});
                n_mb = r_corr ? r_s : 33'(r_rb);
            end
            OP_X_COS: begin
                n_ma = 33'(r_v);
                n_mb = r_c;
            end
            OP_X_SIN: begin
                n_ma = 33'(r_h);
                n_mb = r_s;
            end
            OP_Y_SIN: begin
                n_ma = 33'(r_v);
                n_mb = r_s;
            end
            OP_Y_COS: begin
                n_ma = 33'(r_h);
                n_mb = r_c;
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_prod;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_LEFT;
            r_circ      <= '0;
            r_itw       <= '0;
            r_rb        <= '0;
            r_roff      <= '0;
            r_corr      <= 1'b0;
            r_heading   <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    twodo_pkg::REG_CIRC:    r_circ <= i_cfg_data;
                    twodo_pkg::REG_INV_TW:  r_itw  <= i_cfg_data;
                    twodo_pkg::REG_BACK_R:  r_rb   <= i_cfg_data;
                    twodo_pkg::REG_BACK_OF: r_roff <= i_cfg_data;
                    twodo_pkg::REG_CORR_EN: r_corr <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // the finish state refills the output register itself
            if (r_out_valid && !i_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_lt <= i_left_travel;
                        r_rt <= i_right_travel;
                        r_bt <= i_back_travel;
                        r_op <= OP_LEFT;
                        r_state <= (i_command == twodo_pkg::CMD_SAMPLE) ? ST_MUL_LOAD
                                                                        : ST_FINISH;
                        case (i_command)
                            twodo_pkg::CMD_SAMPLE: ;
                            twodo_pkg::CMD_SET_POS: begin
                                r_x <= i_new_x;
                                r_y <= i_new_y;
                            end
                            twodo_pkg::CMD_SET_HEAD: begin
                                r_heading <= i_new_heading;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL_LOAD: begin
                    r_ma    <= n_ma;
                    r_mb    <= n_mb;
                    r_state <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    r_state <= ST_MUL_DONE;
                end
                ST_MUL_DONE: begin
                    case (r_op)
                        OP_LEFT: begin
                            r_dl    <= 29'(r_p >>> 12);
                            r_op    <= OP_RIGHT;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_RIGHT: begin
                            r_dr    <= 29'(r_p >>> 12);
                            r_op    <= OP_BACK;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_BACK: begin
                            r_db    <= 29'(r_p >>> 12);
                            r_op    <= OP_TURN;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_TURN: begin
                            r_hd    <= 54'(r_p);
                            r_op    <= OP_FRAC_LO;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_FRAC_LO: begin
                            r_fa    <= 64'(r_p);
                            r_op    <= OP_FRAC_HI;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_FRAC_HI: begin
                            r_dang <= n_dang;
                            r_v    <= n_v;
                            r_op   <= OP_SIDE_A;
                            if (r_corr) begin
                                // turn of the heading change for the offset term
                                r_cx      <= twodo_pkg::GAIN_Q30;
                                r_cy      <= '0;
                                r_cz      <= 34'($signed(w_turn_f));
                                r_flip    <= w_flip;
                                r_iter    <= '0;
                                r_state   <= ST_COR_RUN;
                            end else begin
                                r_state   <= ST_MUL_LOAD;
                            end
                        end
                        OP_SIDE_A: begin
                            r_ta    <= r_p;
                            r_op    <= OP_SIDE_B;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_SIDE_B: begin
                            r_h       <= n_h;
                            r_heading <= n_heading;
                            r_op      <= OP_X_COS;
                            r_cx      <= twodo_pkg::GAIN_Q30;
                            r_cy      <= '0;
                            r_cz      <= 34'($signed(w_turn_f));
                            r_flip    <= w_flip;
                            r_iter    <= '0;
                            r_state   <= ST_COR_RUN;
                        end
                        OP_X_COS: begin
                            r_ta    <= r_p;
                            r_op    <= OP_X_SIN;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_X_SIN: begin
                            r_x     <= n_x;
                            r_op    <= OP_Y_SIN;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_Y_SIN: begin
                            r_ta    <= r_p;
                            r_op    <= OP_Y_COS;
                            r_state <= ST_MUL_LOAD;
                        end
                        OP_Y_COS: begin
                            r_y     <= n_y;
                            r_op    <= OP_LEFT;
                            r_state <= ST_FINISH;
                        end
                        default: begin
                            r_state <= ST_FINISH;
                        end
                    endcase
                end
                ST_COR_RUN: begin
                    r_cx   <= n_cx;
                    r_cy   <= n_cy;
                    r_cz   <= n_cz;
                    r_iter <= r_iter + 6'd1;
                    if (w_last) begin
                        r_c     <= 33'(w_cfin_x);
                        r_s     <= 33'(w_cfin_y);
                        r_state <= ST_MUL_LOAD;
                    end
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_ox        <= r_x;
                        r_oy        <= r_y;
                        r_ohead     <= r_heading;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
